>>> hdl/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared types and constants of the battery SoC estimator: curve table
// geometry, curve entry layout, register and command codes and the control
// word of the arithmetic unit.
// ----------------------------------------------------------------------------
package bsoc_pkg;

   localparam int TABLE_STEPS = 1000;
   localparam int TBL_DEPTH   = TABLE_STEPS + 1;
   localparam int TBL_IDX_W   = $clog2(TBL_DEPTH);

   localparam logic [2:0] CSR_SOC_PER_AMP = 3'd0;
   localparam logic [2:0] CSR_OHMIC_RES   = 3'd1;
   localparam logic [2:0] CSR_RES_VAR     = 3'd2;
   localparam logic [2:0] CSR_CUR_VAR     = 3'd3;
   localparam logic [2:0] CSR_VOLT_VAR    = 3'd4;

   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   typedef struct packed {
      logic signed [31:0] slope;
      logic [30:0]        ocv;
   } curve_entry_type;

   typedef struct packed {
      logic        start;
      logic        divide;
      logic [6:0]  shift;
      logic [62:0] lim;
   } mdu_ctl_type;

endpackage

>>> hdl/battery_soc_ekf_rint.sv
// A measurement word runs from acceptance to a registered result as
//   thirteen multiply passes and two multiply-divide passes through the
//   shared arithmetic unit. req_stall holds off new words, table loads
//   included, until the result enters the output register; an output
//   stall can delay that. Reset (synchronous): SoC 0.5, covariance 0.25,
//   registers to defaults; the curve table is not cleared and must be loaded.
// ----------------------------------------------------------------------------
// battery_soc_ekf_rint
// Two-state extended Kalman filter for battery state of charge on an
// internal-resistance cell model, sequenced over one shared arithmetic unit.
// ----------------------------------------------------------------------------
module battery_soc_ekf_rint (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [30:0]                    req_terminal_voltage,
   input  logic signed [31:0]             req_cell_current,
   input  logic [bsoc_pkg::TBL_IDX_W-1:0] req_table_index,
   input  logic [30:0]                    req_table_ocv,
   input  logic signed [31:0]             req_table_slope,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [30:0]                    rsp_soc,
   input  logic                           csr_write_enable,
   input  logic [2:0]                     csr_index,
   input  logic [47:0]                    csr_write_data
);
   import bsoc_pkg::*;

   localparam int FRAC_W   = 31 - $clog2(TABLE_STEPS);
   localparam int SCALED_W = 30 + TBL_IDX_W;
   localparam int E_W      = 53;

   // fraction above the floor index by reciprocal multiplication
   localparam logic [6:0]  FRAC_SH    = 7'd42;
   localparam logic [63:0] FRAC_RECIP =
      ((64'd1 << 42) + 64'(TABLE_STEPS) - 64'd1) / 64'(TABLE_STEPS);

   localparam logic signed [63:0] SOC_ONE  = 64'sd1073741824;
   localparam logic signed [63:0] DROP_LIM = 64'sd8388608;
   localparam logic signed [63:0] P_MAX    = 64'sd140737488355327;
   localparam logic signed [63:0] S_MAX    = 64'sd4611686018427387904;
   localparam logic signed [63:0] OFFSET_V = 64'sd83886;

   localparam logic [62:0] LIM_BIG  = 63'd1125899906842624;
   localparam logic [62:0] LIM_PMAX = 63'd140737488355327;
   localparam logic [62:0] LIM_TERM = 63'd1152921504606846976;
   localparam logic [62:0] LIM_SMAX = 63'd4611686018427387904;

   typedef enum logic [4:0] {
      ST_IDLE, ST_T1, ST_DROP, ST_B2, ST_R2, ST_I2, ST_A, ST_C, ST_D,
      ST_SC, ST_FR, ST_H0, ST_SS, ST_F, ST_K0, ST_N00, ST_OUT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   // configuration
   logic [47:0] spas_ff;
   logic [30:0] ohm_ff;
   logic [47:0] rvar_ff, cvar_ff, vvar_ff;

   // filter state
   logic [30:0]        soc_est_ff;
   logic signed [47:0] cov0_ff;
   logic signed [31:0] prev_cur_ff;

   // per-step working values
   logic signed [31:0]      cur_ff;
   logic [30:0]             volt_ff;
   logic [30:0]             soc_p_ff;
   logic signed [24:0]      drop_p_ff;
   logic [50:0]             b2_ff, r2_ff;
   logic [62:0]             i2_ff;
   logic signed [47:0]      p00_ff, p11_ff;
   logic [46:0]             c_ff;
   logic [SCALED_W-1:0]     scaled_ff;
   logic [TBL_IDX_W-1:0]    idx_ff;
   logic [FRAC_W-1:0]       frac_ff;
   logic signed [47:0]      h0_ff;
   logic [62:0]             s_ff;
   logic signed [E_W-1:0]   e_ff;

   logic        rsp_valid_ff;
   logic [30:0] rsp_soc_ff;

   mdu_ctl_type        mdu_ctl;
   logic signed [63:0] mdu_a, mdu_b;
   logic [62:0]        mdu_d;
   logic               mdu_done;
   logic signed [63:0] mdu_r;

   curve_entry_type rd_entry, wr_entry;
   logic            tbl_wr;

   logic req_accept, op_state, capture;

   logic signed [63:0] soc_dif, p00_sum, p11_sum, s_sum, e_sum, soc_sum, n00_sum;
   logic [30:0]        soc_p_in, soc_in;
   logic signed [24:0] drop_p_in;
   logic signed [47:0] p00_in, p11_in, cov0_in;
   logic [62:0]        s_in;
   logic [TBL_IDX_W-1:0] idx_raw, idx_in;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign op_state   = (state_ff != ST_IDLE) && (state_ff != ST_OUT);
   assign capture    = op_state && busy_ff && mdu_done;

   assign tbl_wr         = req_accept && (req_command == CMD_LOAD)
                           && (32'(req_table_index) <= 32'(TABLE_STEPS));
   assign wr_entry.ocv   = req_table_ocv;
   assign wr_entry.slope = req_table_slope;

   bsoc_curve_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_table_index),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_entry)
   );

   bsoc_mdu u_mdu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mdu_ctl),
      .opa     (mdu_a),
      .opb     (mdu_b),
      .divisor (mdu_d),
      .done    (mdu_done),
      .result  (mdu_r)
   );

   // operand select for the arithmetic pass of each step
   always_comb begin
      mdu_ctl        = '0;
      mdu_ctl.start  = op_state && !busy_ff;
      mdu_ctl.lim    = LIM_BIG;
      mdu_a          = '0;
      mdu_b          = '0;
      mdu_d          = 63'd1;
      case (state_ff)
         ST_T1: begin
            mdu_a = 64'(spas_ff); mdu_b = 64'(prev_cur_ff); mdu_ctl.shift = 7'd34;
         end
         ST_DROP: begin
            mdu_a = 64'(ohm_ff); mdu_b = 64'(cur_ff); mdu_ctl.shift = 7'd20;
         end
         ST_B2: begin
            mdu_a = 64'(spas_ff); mdu_b = 64'(spas_ff); mdu_ctl.shift = 7'd48;
         end
         ST_R2: begin
            mdu_a = 64'(ohm_ff); mdu_b = 64'(ohm_ff); mdu_ctl.shift = 7'd12;
         end
         ST_I2: begin
            mdu_a = 64'(cur_ff); mdu_b = 64'(cur_ff); mdu_ctl.lim = LIM_SMAX;
         end
         ST_A: begin
            mdu_a = 64'(cvar_ff); mdu_b = 64'(b2_ff);
            mdu_ctl.shift = 7'd36; mdu_ctl.lim = LIM_PMAX;
         end
         ST_C: begin
            mdu_a = 64'(rvar_ff); mdu_b = 64'(i2_ff);
            mdu_ctl.shift = 7'd20; mdu_ctl.lim = LIM_PMAX;
         end
         ST_D: begin
            mdu_a = 64'(cvar_ff); mdu_b = 64'(r2_ff);
            mdu_ctl.shift = 7'd32; mdu_ctl.lim = LIM_PMAX;
         end
         ST_SC: begin
            mdu_a = 64'(soc_p_ff); mdu_b = 64'(TABLE_STEPS);
         end
         ST_FR: begin
            mdu_a = 64'(scaled_ff[29:0]); mdu_b = FRAC_RECIP;
            mdu_ctl.shift = FRAC_SH;
         end
         ST_H0: begin
            mdu_a = 64'(rd_entry.slope); mdu_b = 64'(p00_ff);
            mdu_ctl.shift = 7'd24; mdu_ctl.lim = LIM_PMAX;
         end
         ST_SS: begin
            mdu_a = 64'(rd_entry.slope); mdu_b = 64'(h0_ff);
            mdu_ctl.shift = 7'd24; mdu_ctl.lim = LIM_TERM;
         end
         ST_F: begin
            mdu_a = 64'(rd_entry.slope); mdu_b = 64'(frac_ff); mdu_ctl.shift = 7'd30;
         end
         ST_K0: begin
            mdu_a = 64'(h0_ff); mdu_b = 64'(e_ff) <<< 6;
            mdu_d = s_ff; mdu_ctl.divide = 1'b1;
         end
         ST_N00: begin
            mdu_a = 64'(h0_ff); mdu_b = 64'(h0_ff);
            mdu_d = s_ff; mdu_ctl.divide = 1'b1;
         end
         default: begin
            mdu_ctl.start = 1'b0;
         end
      endcase
   end

   // clamps applied as each pass returns
   always_comb begin
      soc_dif = $signed({33'd0, soc_est_ff}) - mdu_r;
      if (soc_dif < 0)            soc_p_in = '0;
      else if (soc_dif > SOC_ONE) soc_p_in = 31'(SOC_ONE);
      else                        soc_p_in = soc_dif[30:0];

      if (mdu_r < -DROP_LIM)      drop_p_in = 25'(-DROP_LIM);
      else if (mdu_r > DROP_LIM)  drop_p_in = 25'(DROP_LIM);
      else                        drop_p_in = mdu_r[24:0];

      p00_sum = 64'(cov0_ff) + mdu_r;
      if (p00_sum < -P_MAX)       p00_in = 48'(-P_MAX);
      else if (p00_sum > P_MAX)   p00_in = 48'(P_MAX);
      else                        p00_in = p00_sum[47:0];

      p11_sum = $signed(64'(c_ff)) + mdu_r;
      if (p11_sum < -P_MAX)       p11_in = 48'(-P_MAX);
      else if (p11_sum > P_MAX)   p11_in = 48'(P_MAX);
      else                        p11_in = p11_sum[47:0];

      idx_raw = mdu_r[SCALED_W-1:30];
      idx_in  = (32'(idx_raw) > 32'(TABLE_STEPS)) ? TBL_IDX_W'(TABLE_STEPS) : idx_raw;

      s_sum = mdu_r + 64'(p11_ff) + $signed(64'(vvar_ff) << 12);
      if (s_sum < 64'sd1)         s_in = 63'd1;
      else if (s_sum > S_MAX)     s_in = 63'(S_MAX);
      else                        s_in = s_sum[62:0];

      e_sum = $signed({33'd0, volt_ff})
              - ($signed({33'd0, rd_entry.ocv}) + mdu_r + OFFSET_V - 64'(drop_p_ff));

      soc_sum = $signed({33'd0, soc_p_ff}) + mdu_r;
      if (soc_sum < 0)            soc_in = '0;
      else if (soc_sum > SOC_ONE) soc_in = 31'(SOC_ONE);
      else                        soc_in = soc_sum[30:0];

      n00_sum = 64'(p00_ff) - mdu_r;
      if (n00_sum < -P_MAX)       cov0_in = 48'(-P_MAX);
      else if (n00_sum > P_MAX)   cov0_in = 48'(P_MAX);
      else                        cov0_in = n00_sum[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         spas_ff      <= '0;
         ohm_ff       <= '0;
         rvar_ff      <= '0;
         cvar_ff      <= '0;
         vvar_ff      <= 48'd4294967;
         soc_est_ff   <= 31'd536870912;
         cov0_ff      <= 48'sd4398046511104;
         prev_cur_ff  <= '0;
         idx_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SOC_PER_AMP: spas_ff <= csr_write_data;
               CSR_OHMIC_RES:   ohm_ff  <= csr_write_data[30:0];
               CSR_RES_VAR:     rvar_ff <= csr_write_data;
               CSR_CUR_VAR:     cvar_ff <= csr_write_data;
               CSR_VOLT_VAR:    vvar_ff <= csr_write_data;
               default:         ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mdu_ctl.start) begin
            busy_ff <= 1'b1;
         end
         if (capture) begin
            busy_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_command != CMD_LOAD)) begin
                  cur_ff   <= req_cell_current;
                  volt_ff  <= req_terminal_voltage;
                  state_ff <= ST_T1;
               end
            end
            ST_T1:   if (capture) begin soc_p_ff  <= soc_p_in;     state_ff <= ST_DROP; end
            ST_DROP: if (capture) begin drop_p_ff <= drop_p_in;    state_ff <= ST_B2;   end
            ST_B2:   if (capture) begin b2_ff     <= mdu_r[50:0];  state_ff <= ST_R2;   end
            ST_R2:   if (capture) begin r2_ff     <= mdu_r[50:0];  state_ff <= ST_I2;   end
            ST_I2:   if (capture) begin i2_ff     <= mdu_r[62:0];  state_ff <= ST_A;    end
            ST_A:    if (capture) begin p00_ff    <= p00_in;       state_ff <= ST_C;    end
            ST_C:    if (capture) begin c_ff      <= mdu_r[46:0];  state_ff <= ST_D;    end
            ST_D:    if (capture) begin p11_ff    <= p11_in;       state_ff <= ST_SC;   end
            ST_SC: begin
               if (capture) begin
                  scaled_ff <= mdu_r[SCALED_W-1:0];
                  idx_ff    <= idx_in;
                  state_ff  <= ST_FR;
               end
            end
            ST_FR:   if (capture) begin frac_ff <= mdu_r[FRAC_W-1:0]; state_ff <= ST_H0; end
            ST_H0:   if (capture) begin h0_ff   <= mdu_r[47:0];       state_ff <= ST_SS; end
            ST_SS:   if (capture) begin s_ff    <= s_in;              state_ff <= ST_F;  end
            ST_F:    if (capture) begin e_ff    <= e_sum[E_W-1:0];    state_ff <= ST_K0; end
            ST_K0:   if (capture) begin soc_est_ff <= soc_in;         state_ff <= ST_N00; end
            ST_N00:  if (capture) begin cov0_ff    <= cov0_in;        state_ff <= ST_OUT; end
            ST_OUT: begin
               // hold until the previous word has left the output register
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_soc_ff   <= soc_est_ff;
                  prev_cur_ff  <= cur_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_soc   = rsp_soc_ff;

endmodule

>>> hdl/bsoc_mdu.sv
// ----------------------------------------------------------------------------
// bsoc_mdu
// Shared multiply / multiply-divide unit. Forms |a|*|b| from four 32x32
// partial products, optionally divides the 128-bit product by a divisor one
// quotient bit per cycle, then shifts, saturates and restores the sign.
// ----------------------------------------------------------------------------
module bsoc_mdu (
   input  logic                  clock,
   input  logic                  reset,
   input  bsoc_pkg::mdu_ctl_type ctl,
   input  logic signed [63:0]    opa,
   input  logic signed [63:0]    opb,
   input  logic [62:0]           divisor,
   output logic                  done,
   output logic signed [63:0]    result
);
   import bsoc_pkg::*;

   typedef enum logic [2:0] {M_IDLE, M_PROD, M_DIV, M_SAT, M_DONE} mstate_type;

   mstate_type         state_ff;
   logic [63:0]        am_ff, bm_ff;
   logic               neg_ff, divide_ff;
   logic [6:0]         shift_ff;
   logic [62:0]        lim_ff, dv_ff;
   logic [127:0]       acc_ff;
   logic [63:0]        pp_ff;
   logic [1:0]         pp_sel_ff;
   logic [2:0]         pcnt_ff;
   logic [6:0]         dcnt_ff;
   logic [62:0]        rem_ff;
   logic signed [63:0] result_ff;

   logic [63:0]        a_mag, b_mag;
   logic [31:0]        a_half, b_half;
   logic [63:0]        pp;
   logic [127:0]       pp_sh;
   logic [63:0]        rem_next;
   logic               ge;
   logic [127:0]       shifted;
   logic               over;
   logic [62:0]        mag;
   logic signed [63:0] mag_s;

   assign a_mag = opa[63] ? 64'(-opa) : 64'(opa);
   assign b_mag = opb[63] ? 64'(-opb) : 64'(opb);

   always_comb begin
      a_half = pcnt_ff[1] ? am_ff[63:32] : am_ff[31:0];
      b_half = pcnt_ff[0] ? bm_ff[63:32] : bm_ff[31:0];
      pp     = a_half * b_half;
      case (pp_sel_ff)
         2'd0:    pp_sh = {64'd0, pp_ff};
         2'd3:    pp_sh = {pp_ff, 64'd0};
         default: pp_sh = {32'd0, pp_ff, 32'd0};
      endcase
   end

   // one restoring division step
   assign rem_next = {rem_ff, acc_ff[127]};
   assign ge       = rem_next >= {1'b0, dv_ff};

   always_comb begin
      shifted = acc_ff >> shift_ff;
      over    = (|shifted[127:63]) || (shifted[62:0] > lim_ff);
      mag     = over ? lim_ff : shifted[62:0];
      mag_s   = signed'({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         case (state_ff)
            M_IDLE: begin
               if (ctl.start) begin
                  am_ff     <= a_mag;
                  bm_ff     <= b_mag;
                  neg_ff    <= opa[63] != opb[63];
                  divide_ff <= ctl.divide;
                  shift_ff  <= ctl.shift;
                  lim_ff    <= ctl.lim;
                  dv_ff     <= divisor;
                  acc_ff    <= '0;
                  pcnt_ff   <= '0;
                  state_ff  <= M_PROD;
               end
            end
            M_PROD: begin
               if (pcnt_ff != 3'd4) begin
                  pp_ff     <= pp;
                  pp_sel_ff <= pcnt_ff[1:0];
               end
               if (pcnt_ff != 3'd0) begin
                  acc_ff <= acc_ff + pp_sh;
               end
               pcnt_ff <= pcnt_ff + 3'd1;
               if (pcnt_ff == 3'd4) begin
                  rem_ff   <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= divide_ff ? M_DIV : M_SAT;
               end
            end
            M_DIV: begin
               // dividend shifts out the top while quotient bits shift in
               rem_ff  <= ge ? 63'(rem_next - {1'b0, dv_ff}) : rem_next[62:0];
               acc_ff  <= {acc_ff[126:0], ge};
               dcnt_ff <= dcnt_ff + 7'd1;
               if (dcnt_ff == 7'd127) begin
                  state_ff <= M_SAT;
               end
            end
            M_SAT: begin
               result_ff <= neg_ff ? -mag_s : mag_s;
               state_ff  <= M_DONE;
            end
            M_DONE: begin
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign done   = state_ff == M_DONE;
   assign result = result_ff;

endmodule

>>> hdl/bsoc_curve_table.sv
// ----------------------------------------------------------------------------
// bsoc_curve_table
// Open-circuit voltage curve: one entry per SoC step, ocv and slope.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsoc_curve_table (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [bsoc_pkg::TBL_IDX_W-1:0] wr_addr,
   input  bsoc_pkg::curve_entry_type      wr_data,
   input  logic [bsoc_pkg::TBL_IDX_W-1:0] rd_addr,
   output bsoc_pkg::curve_entry_type      rd_data
);
   import bsoc_pkg::*;

   curve_entry_type mem [TBL_DEPTH];
   curve_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/battery_soc_ekf_rint_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_soc_ekf_rint_test
// Self-checking bench for the SoC estimator. It loads the curve table, then
// drives directed and random measurement and load words under several
// register settings. Random request idles and response stalls are applied.
// Each result word is compared against a bit-exact filter predictor.
// ----------------------------------------------------------------------------
module battery_soc_ekf_rint_test;
   import bsoc_pkg::*;

   localparam int   CURVE_LAST  = bsoc_pkg::TABLE_STEPS;
   localparam longint SOC_FULL  = 64'sd1 << 30;
   localparam longint DROP_MAX  = 64'sd1 << 23;
   localparam longint COV_MAX   = (64'sd1 << 47) - 1;
   localparam longint SAT_BIG   = 64'sd1 << 50;
   localparam longint TERM_CAP  = 64'sd1 << 60;
   localparam longint INNOV_CAP = 64'sd1 << 62;
   localparam longint V_OFFSET  = 83886;
   localparam longint OCV_BASE  = 50331648;   // 3.0 V
   localparam longint OCV_SPAN  = 20132659;   // 1.2 V

   class soc_scoreboard;
      longint unsigned amp_step, r_ohm, r_var, i_var, v_var;
      longint soc_est, p00_est, prev_cur;
      logic [30:0]        curve_ocv [0:CURVE_LAST];
      logic signed [31:0] curve_slope [0:CURVE_LAST];
      bit [30:0] soc_queue[$];

      function new();
         amp_step = 0; r_ohm = 0; r_var = 0; i_var = 0; v_var = 4294967;
         soc_est = 64'sd1 << 29;
         p00_est = 64'sd1 << 42;
         prev_cur = 0;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // magnitude product, truncated shift, saturate, restore sign
      function longint mul_shift(longint a, longint b, int sh, longint lim);
         logic [63:0]  ua, ub, m;
         logic [127:0] prod;
         ua = a < 0 ? -a : a;
         ub = b < 0 ? -b : b;
         prod = ({64'd0, ua} * {64'd0, ub}) >> sh;
         m = (prod > {64'd0, lim}) ? lim : prod[63:0];
         return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
      endfunction

      function longint mul_div(longint a, longint b, longint d, longint lim);
         logic [63:0]  ua, ub, m;
         logic [127:0] prod;
         ua = a < 0 ? -a : a;
         ub = b < 0 ? -b : b;
         prod = ({64'd0, ua} * {64'd0, ub}) / {64'd0, d};
         m = (prod > {64'd0, lim}) ? lim : prod[63:0];
         return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
      endfunction

      function void set_reg(logic [2:0] idx, logic [47:0] data);
         case (idx)
            CSR_SOC_PER_AMP: amp_step = 64'(data);
            CSR_OHMIC_RES:   r_ohm = 64'(data[30:0]);
            CSR_RES_VAR:     r_var = 64'(data);
            CSR_CUR_VAR:     i_var = 64'(data);
            CSR_VOLT_VAR:    v_var = 64'(data);
            default: ;
         endcase
      endfunction

      function void note(logic cmd, logic [30:0] volt_in, logic signed [31:0] cur_in,
                         logic [9:0] idx_in, logic [30:0] ocv_in,
                         logic signed [31:0] slope_in);
         longint volt, cur, soc, drop, b2, r2, i2, p00, p11, h0, h1, s, zp, e;
         longint ocv, slope;
         longint unsigned scaled, idx, frac;
         if (cmd == CMD_LOAD) begin
            if (idx_in <= CURVE_LAST) begin
               curve_ocv[idx_in] = ocv_in;
               curve_slope[idx_in] = slope_in;
            end
            return;
         end
         volt = longint'({33'd0, volt_in});
         cur = longint'(cur_in);
         soc = clamp(soc_est - mul_shift(amp_step, prev_cur, 34, SAT_BIG), 0, SOC_FULL);
         drop = clamp(mul_shift(r_ohm, cur, 20, SAT_BIG), -DROP_MAX, DROP_MAX);
         b2 = mul_shift(amp_step, amp_step, 48, SAT_BIG);
         r2 = mul_shift(r_ohm, r_ohm, 12, SAT_BIG);
         i2 = mul_shift(cur, cur, 0, INNOV_CAP);
         p00 = clamp(p00_est + mul_shift(i_var, b2, 36, COV_MAX), -COV_MAX, COV_MAX);
         p11 = clamp(mul_shift(r_var, i2, 20, COV_MAX) + mul_shift(i_var, r2, 32, COV_MAX),
                     -COV_MAX, COV_MAX);
         scaled = longint'(soc) * CURVE_LAST;
         idx = scaled >> 30;
         if (idx > CURVE_LAST) idx = CURVE_LAST;
         frac = (scaled & ((64'd1 << 30) - 1)) / CURVE_LAST;
         ocv = longint'({33'd0, curve_ocv[idx]});
         slope = longint'(curve_slope[idx]);
         h0 = mul_shift(slope, p00, 24, COV_MAX);
         h1 = -p11;
         s = mul_shift(slope, h0, 24, TERM_CAP) + p11 + longint'(v_var << 12);
         s = clamp(s, 1, INNOV_CAP);
         zp = ocv + mul_shift(slope, frac, 30, SAT_BIG) + V_OFFSET - drop;
         e = volt - zp;
         soc = clamp(soc + mul_div(h0, e * 64, s, SAT_BIG), 0, SOC_FULL);
         p00_est = clamp(p00 - mul_div(h0, h0, s, SAT_BIG), -COV_MAX, COV_MAX);
         soc_est = soc;
         prev_cur = cur;
         soc_queue.push_back(soc[30:0]);
      endfunction

      // 0 ok, 1 mismatch, 2 nothing waiting
      function int check(logic [30:0] got, output logic [30:0] want);
         want = '0;
         if (soc_queue.size() == 0) return 2;
         want = soc_queue.pop_front();
         return (got === want) ? 0 : 1;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_MEASURE;
   logic [30:0] req_terminal_voltage = '0;
   logic signed [31:0] req_cell_current = '0;
   logic [bsoc_pkg::TBL_IDX_W-1:0] req_table_index = '0;
   logic [30:0] req_table_ocv = '0;
   logic signed [31:0] req_table_slope = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [30:0] rsp_soc;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_write_data = '0;

   soc_scoreboard sb = new();
   int  errors = 0;
   bit  no_idle = 1'b0;

   battery_soc_ekf_rint u_top (.*);

   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      logic [30:0] want;
      int st;
      if (!reset && req_valid && !req_stall)
         sb.note(req_command, req_terminal_voltage, req_cell_current, req_table_index,
                 req_table_ocv, req_table_slope);
      if (!reset && rsp_valid && !rsp_stall) begin
         st = sb.check(rsp_soc, want);
         if (st == 2) report($sformatf("result word %0d with none expected", rsp_soc));
         else if (st == 1) report($sformatf("soc got %0d want %0d", rsp_soc, want));
      end
   end

   always @(posedge clock)
      rsp_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 24);

   task automatic send(logic cmd, logic [30:0] volt, logic signed [31:0] cur,
                       logic [9:0] idx, logic [30:0] ocv, logic signed [31:0] slope);
      bit stalled;
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_terminal_voltage <= volt;
      req_cell_current <= cur;
      req_table_index <= idx;
      req_table_ocv <= ocv;
      req_table_slope <= slope;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic load_curve(int idx);
      send(CMD_LOAD, 31'($urandom), $urandom, idx[9:0],
           31'(OCV_BASE + OCV_SPAN * idx / CURVE_LAST + $urandom_range(0, 4095)),
           32'(OCV_SPAN + $urandom_range(0, 2000000) - 1000000));
   endtask

   task automatic random_word();
      int pick;
      logic [30:0] volt;
      logic signed [31:0] cur;
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
         load_curve($urandom_range(0, CURVE_LAST));
      end else if (pick < 38) begin
         send(CMD_LOAD, 31'($urandom), $urandom, 10'($urandom_range(0, CURVE_LAST)),
              31'($urandom), $urandom);
      end else if (pick < 40) begin
         send(CMD_LOAD, 31'($urandom), $urandom,
              10'($urandom_range(CURVE_LAST + 1, 1023)), 31'($urandom), $urandom);
      end else begin
         volt = ($urandom_range(0, 3) != 0) ?
                31'(OCV_BASE + $urandom_range(0, 25000000)) : 31'($urandom);
         cur = ($urandom_range(0, 9) < 7) ?
               32'($signed($urandom_range(0, 1310720)) - 655360) : $urandom;
         send(CMD_MEASURE, volt, cur, 10'($urandom), 31'($urandom), $urandom);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.soc_queue.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic set_phase(int phase);
      logic [47:0] vals [5];
      case (phase)
         0: vals = '{48'd39093746765, 48'd13421773, 48'd4295, 48'd42949673, 48'd4294967};
         1: vals = '{48'd0, 48'd0, 48'd0, 48'd0, 48'd0};
         2: vals = '{'1, '1, '1, '1, '1};
         default: vals = '{48'({$urandom, $urandom} >> $urandom_range(0, 40)),
                           48'($urandom_range(0, 30000000)),
                           48'($urandom_range(0, 100000)),
                           48'({$urandom, $urandom} >> $urandom_range(8, 40)),
                           48'($urandom_range(1, 100000000))};
      endcase
      for (int i = 0; i < 5; i++) write_reg(3'(i), vals[i]);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_phase(0);
      // fill the whole curve before any lookup
      no_idle = 1'b1;
      for (int i = 0; i <= CURVE_LAST; i++) load_curve(i);
      no_idle = 1'b0;
      send(CMD_LOAD, '0, '0, 10'(CURVE_LAST + 1), '1, '1);
      send(CMD_LOAD, '0, '0, 10'h3FF, '1, '1);
      send(CMD_MEASURE, '0, '0, '0, '0, '0);
      send(CMD_MEASURE, '1, 32'sh7FFFFFFF, '1, '1, '1);
      send(CMD_MEASURE, '0, 32'sh80000000, '0, '0, '0);
      send(CMD_MEASURE, 31'(OCV_BASE + OCV_SPAN / 2), 32'sd65536, '0, '0, '0);
      send(CMD_MEASURE, 31'(OCV_BASE), -32'sd655360, '0, '0, '0);
      send(CMD_LOAD, '0, '0, 10'd500, '1, 32'sh7FFFFFFF);
      send(CMD_LOAD, '0, '0, 10'd0, '0, 32'sh80000000);
      send(CMD_MEASURE, '1, 32'sd1000, '0, '0, '0);
      send(CMD_MEASURE, '0, -32'sd1000, '0, '0, '0);
      load_curve(500);
      load_curve(0);
      for (int phase = 0; phase < 4; phase++) begin
         if (phase != 0) begin
            drain();
            set_phase(phase);
         end
         for (int n = 0; n < 250; n++) begin
            no_idle = (phase == 0 && n >= 100 && n < 175);
            random_word();
         end
         no_idle = 1'b0;
      end
      drain();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
